// ===== hw/rtl/rpr_pkg.sv =====
// Shared types and constants for the rectilinear path point reducer.
package rpr_pkg;

    localparam int MAX_POINTS_DEF = 256;

    localparam logic [1:0] REQ_APPEND = 2'd0;
    localparam logic [1:0] REQ_READ   = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    typedef enum logic [2:0] {
        ACT_DUP         = 3'd0,
        ACT_APPEND      = 3'd1,
        ACT_SEP         = 3'd2,
        ACT_SPIKE_REPL  = 3'd3,
        ACT_SPIKE_ELIDE = 3'd4,
        ACT_READ        = 3'd5,
        ACT_CLEAR       = 3'd6,
        ACT_ERROR       = 3'd7
    } t_action;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
    } t_vertex;

    typedef struct packed {
        logic [1:0]  req_type;
        t_vertex     pt;
        logic [7:0]  read_index;
    } t_req;

endpackage

// ===== hw/rtl/rpr_if.sv =====
// Request and result word channels of the path point reducer.
interface rpr_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [7:0]         read_index;

    modport source (output valid, req_type, point_x, point_y, read_index, input ready);
    modport sink   (input valid, req_type, point_x, point_y, read_index, output ready);
endinterface

interface rpr_res_if;
    logic               valid;
    logic               ready;
    logic [2:0]         action;
    logic [8:0]         stack_depth;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;

    modport source (output valid, action, stack_depth, out_x, out_y, input ready);
    modport sink   (input valid, action, stack_depth, out_x, out_y, output ready);
endinterface

// ===== hw/rtl/rpr_ram.sv =====
// Generic simple dual-port RAM with registered read.
module rpr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/rpr_judge.sv =====
// Reduction decision on the top three points (p2 oldest, p0 newest).
module rpr_judge
    import rpr_pkg::*;
(
    input  t_vertex i_p2,
    input  t_vertex i_p1,
    input  t_vertex i_p0,
    output t_action o_action
);
    function automatic logic f_sep(logic signed [31:0] a2, logic signed [31:0] a1,
                                   logic signed [31:0] a0);
        return (a2 < a1 && a1 < a0) || (a0 < a1 && a1 < a2);
    endfunction

    // 0 none, 1 replace, 2 elide
    function automatic logic [1:0] f_spike(logic signed [31:0] a2, logic signed [31:0] a1,
                                           logic signed [31:0] a0);
        logic [1:0] k;
        k = 2'd0;
        if ((a1 < a0 && a0 < a2) || (a2 < a0 && a0 < a1) ||
            (a1 < a2 && a2 < a0) || (a0 < a2 && a2 < a1)) begin
            k = 2'd1;
        end else if ((a2 == a0 && a0 < a1) || (a1 < a0 && a0 == a2)) begin
            k = 2'd2;
        end
        return k;
    endfunction

    logic       col_x;
    logic       col_y;
    logic       sep;
    logic [1:0] kind_x;
    logic [1:0] kind_y;
    logic [1:0] kind;

    always_comb begin
        col_x  = (i_p0.x == i_p1.x) && (i_p1.x == i_p2.x);
        col_y  = (i_p0.y == i_p1.y) && (i_p1.y == i_p2.y);
        sep    = (col_x && f_sep(i_p2.y, i_p1.y, i_p0.y)) ||
                 (col_y && f_sep(i_p2.x, i_p1.x, i_p0.x));
        kind_x = col_x ? f_spike(i_p2.y, i_p1.y, i_p0.y) : 2'd0;
        kind_y = col_y ? f_spike(i_p2.x, i_p1.x, i_p0.x) : 2'd0;
        kind   = (kind_x != 2'd0) ? kind_x : kind_y;
        priority if (sep) begin
            o_action = ACT_SEP;
        end else if (kind == 2'd2) begin
            o_action = ACT_SPIKE_ELIDE;
        end else if (kind == 2'd1) begin
            o_action = ACT_SPIKE_REPL;
        end else begin
            o_action = ACT_APPEND;
        end
    end
endmodule

// ===== hw/rtl/rectilinear_path_point_reducer_top.sv =====
// Top level of the rectilinear path point reducer.
//
//  channel   dir  words carried
//  i_req     in   req_type, point_x, point_y, read_index
//  o_res     out  action, stack_depth, out_x, out_y (one per request)
//
// A request is accepted (memory read issued), then decided and written back.
// A spike elision with three or more points held adds a fetch step: the entry below the new top
// is refetched from the vertex RAM.
// The top two vertices are held in registers; the RAM keeps every entry.
// Reset clears the count, the state and the result valid; RAM contents are undefined
// until written.
// A stalled result holds the block in its decide step; nothing is lost.
module rectilinear_path_point_reducer_top
    import rpr_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rpr_req_if.sink    i_req,
    rpr_res_if.source  o_res
);
    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FETCH
    } t_state;

    t_state          r_state;
    t_req            r_req;
    logic [CW-1:0]   r_count;
    t_vertex         r_p0;
    t_vertex         r_p1;
    logic            r_ovalid;
    t_action         r_oaction;
    logic [8:0]      r_odepth;
    t_vertex         r_opt;

    logic            accept;
    logic            fire;
    logic            dup;
    logic            full;
    logic            idx_ok;
    t_action         judge;
    t_action         n_action;
    logic [CW-1:0]   n_count;
    t_vertex         n_opt;
    logic [CW-1:0]   cnt_m1;
    logic [CW-1:0]   cnt_m3;
    logic [CW+7:0]   idx_ext;
    logic [CW+7:0]   cnt_ext8;
    logic [CW+8:0]   depth_ext;
    logic [AW+7:0]   idx_addr;
    logic            we;
    logic [AW-1:0]   waddr;
    logic            re;
    logic [AW-1:0]   raddr;
    logic            refetch;
    t_vertex         rdata;

    assign accept = i_req.valid && i_req.ready;
    assign fire   = (r_state == S_EXEC) && (!r_ovalid || o_res.ready);

    rpr_judge u_judge (
        .i_p2     (r_p1),
        .i_p1     (r_p0),
        .i_p0     (r_req.pt),
        .o_action (judge)
    );

    rpr_ram #(
        .WIDTH ($bits(t_vertex)),
        .DEPTH (MAX_POINTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (r_req.pt),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        cnt_m1   = r_count - CW'(1);
        cnt_m3   = r_count - CW'(3);
        idx_ext  = {{CW{1'b0}}, r_req.read_index};
        cnt_ext8 = {8'd0, r_count};
        idx_addr = {{AW{1'b0}}, i_req.read_index};
        dup      = (r_count != '0) && (r_p0 == r_req.pt);
        full     = (r_count == CW'(MAX_POINTS));
        idx_ok   = idx_ext < cnt_ext8;

        n_action = ACT_ERROR;
        n_count  = r_count;
        n_opt    = '0;
        we       = 1'b0;
        waddr    = r_count[AW-1:0];
        refetch  = 1'b0;

        unique case (r_req.req_type)
            REQ_APPEND: begin
                if (dup) begin
                    n_action = ACT_DUP;
                    n_opt    = r_req.pt;
                end else if (full) begin
                    n_action = ACT_ERROR;
                end else begin
                    n_action = (r_count >= CW'(2)) ? judge : ACT_APPEND;
                    unique case (n_action)
                        ACT_SEP, ACT_SPIKE_REPL: begin
                            we    = fire;
                            waddr = cnt_m1[AW-1:0];
                            n_opt = r_req.pt;
                        end
                        ACT_SPIKE_ELIDE: begin
                            n_count = cnt_m1;
                            n_opt   = r_p1;
                            refetch = r_count >= CW'(3);
                        end
                        default: begin
                            we      = fire;
                            n_count = r_count + CW'(1);
                            n_opt   = r_req.pt;
                        end
                    endcase
                end
            end
            REQ_READ: begin
                if (idx_ok) begin
                    n_action = ACT_READ;
                    n_opt    = rdata;
                end
            end
            REQ_CLEAR: begin
                n_action = ACT_CLEAR;
                n_count  = '0;
            end
            default: begin
                n_action = ACT_ERROR;
            end
        endcase

        depth_ext = {9'd0, n_count};
        re        = accept || (fire && refetch);
        raddr     = accept ? idx_addr[AW-1:0] : cnt_m3[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_res.ready && !fire) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_req   <= '{req_type:   i_req.req_type,
                                     pt:         '{x: i_req.point_x, y: i_req.point_y},
                                     read_index: i_req.read_index};
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (fire) begin
                        r_ovalid  <= 1'b1;
                        r_oaction <= n_action;
                        r_odepth  <= depth_ext[8:0];
                        r_opt     <= n_opt;
                        r_count   <= n_count;
                        r_state   <= refetch ? S_FETCH : S_IDLE;
                        if (r_req.req_type == REQ_APPEND && !dup && !full) begin
                            unique case (n_action)
                                ACT_SEP, ACT_SPIKE_REPL: begin
                                    r_p0 <= r_req.pt;
                                end
                                ACT_SPIKE_ELIDE: begin
                                    r_p0 <= r_p1;
                                end
                                default: begin
                                    r_p1 <= r_p0;
                                    r_p0 <= r_req.pt;
                                end
                            endcase
                        end
                    end
                end
                S_FETCH: begin
                    r_p1    <= rdata;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_res.valid       = r_ovalid;
    assign o_res.action      = r_oaction;
    assign o_res.stack_depth = r_odepth;
    assign o_res.out_x       = r_opt.x;
    assign o_res.out_y       = r_opt.y;
endmodule

// ===== sim/rectilinear_path_point_reducer_top_tb.sv =====
// Self-checking testbench for the rectilinear path point reducer: directed cases, random paths.
module rectilinear_path_point_reducer_top_tb;
    import rpr_pkg::*;

    localparam int ITEMS       = 750;
    localparam int QUIET_TAIL  = 100;
    localparam int STALL_LIMIT = 2000;

    localparam logic [1:0]         REQ_UNDEFINED = 2'd3;
    localparam logic signed [31:0] S32_MIN       = 32'sh8000_0000;
    localparam logic signed [31:0] S32_MAX       = 32'sh7fff_ffff;

    typedef struct {
        t_action            action;
        logic [8:0]         depth;
        logic signed [31:0] x;
        logic signed [31:0] y;
    } t_outcome;

    // Mirror of the vertex stack; predicts one result word per request.
    class path_tracker;
        t_vertex     verts [MAX_POINTS_DEF];
        int unsigned depth;
        t_outcome    pending_results [$];
        int          errors;

        function new();
            depth  = 0;
            errors = 0;
        endfunction

        function bit between(logic signed [31:0] a, logic signed [31:0] b,
                             logic signed [31:0] c);
            return (a < b && b < c) || (c < b && b < a);
        endfunction

        function t_action spike_kind(logic signed [31:0] a2, logic signed [31:0] a1,
                                     logic signed [31:0] a0);
            if (between(a1, a0, a2) || between(a1, a2, a0))
                return ACT_SPIKE_REPL;
            if (a2 == a0 && a0 != a1)
                return ACT_SPIKE_ELIDE;
            return ACT_APPEND;
        endfunction

        function t_action fold_top();
            t_vertex p0, p1, p2;
            t_action kind;
            bit      same_x, same_y;
            if (depth < 3)
                return ACT_APPEND;
            p0 = verts[depth-1];
            p1 = verts[depth-2];
            p2 = verts[depth-3];
            same_x = (p0.x == p1.x) && (p1.x == p2.x);
            same_y = (p0.y == p1.y) && (p1.y == p2.y);
            // separator test takes priority over spikes
            if ((same_x && between(p2.y, p1.y, p0.y)) ||
                (same_y && between(p2.x, p1.x, p0.x))) begin
                verts[depth-2] = p0;
                depth--;
                return ACT_SEP;
            end
            kind = ACT_APPEND;
            if (same_x)
                kind = spike_kind(p2.y, p1.y, p0.y);
            if (kind == ACT_APPEND && same_y)
                kind = spike_kind(p2.x, p1.x, p0.x);
            if (kind == ACT_SPIKE_ELIDE) begin
                depth -= 2;
            end else if (kind == ACT_SPIKE_REPL) begin
                verts[depth-2] = p0;
                depth--;
            end
            return kind;
        endfunction

        function void note_request(t_req r);
            t_outcome o;
            o.action = ACT_ERROR;
            o.x      = '0;
            o.y      = '0;
            case (r.req_type)
                REQ_APPEND: begin
                    if (depth > 0 && verts[depth-1] == r.pt) begin
                        o.action = ACT_DUP;
                        o.x      = r.pt.x;
                        o.y      = r.pt.y;
                    end else if (depth < MAX_POINTS_DEF) begin
                        verts[depth] = r.pt;
                        depth++;
                        o.action = fold_top();
                        if (depth > 0) begin
                            o.x = verts[depth-1].x;
                            o.y = verts[depth-1].y;
                        end
                    end
                end
                REQ_READ: begin
                    if (r.read_index < depth) begin
                        o.action = ACT_READ;
                        o.x      = verts[r.read_index].x;
                        o.y      = verts[r.read_index].y;
                    end
                end
                REQ_CLEAR: begin
                    depth    = 0;
                    o.action = ACT_CLEAR;
                end
                default: ;
            endcase
            o.depth = 9'(depth);
            pending_results = {pending_results, o};
        endfunction

        function void check_result(logic [2:0] act, logic [8:0] dep,
                                   logic signed [31:0] x, logic signed [31:0] y);
            t_outcome want;
            if (pending_results.size() == 0) begin
                $error("result word with nothing pending: action %0d", act);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (act !== want.action) begin
                $error("action: expected %0d, got %0d", want.action, act);
                errors++;
            end
            if (dep !== want.depth) begin
                $error("stack_depth: expected %0d, got %0d", want.depth, dep);
                errors++;
            end
            if (x !== want.x) begin
                $error("out_x: expected %0d, got %0d", want.x, x);
                errors++;
            end
            if (y !== want.y) begin
                $error("out_y: expected %0d, got %0d", want.y, y);
                errors++;
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    int   idle_pct;
    int   sent;
    int   quiet_cycles = 0;
    path_tracker sb;

    rpr_req_if req_ch ();
    rpr_res_if res_ch ();

    rectilinear_path_point_reducer_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready)
            sb.check_result(res_ch.action, res_ch.stack_depth, res_ch.out_x, res_ch.out_y);
    end

    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("rectilinear_path_point_reducer_top regression: fail");
                $finish;
            end
        end
    end

    // result back-pressure in bursts
    initial begin
        int left;
        res_ch.ready = 1'b0;
        left = 0;
        forever begin
            @(negedge i_clk);
            if (left > 0) begin
                left--;
                res_ch.ready <= 1'b0;
            end else if ($urandom_range(0, 99) < idle_pct) begin
                left = $urandom_range(1, 13) - 1;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    function automatic t_req make_req(logic [1:0] kind, logic signed [31:0] x,
                                      logic signed [31:0] y, logic [7:0] idx);
        t_req r;
        r.req_type   = kind;
        r.pt.x       = x;
        r.pt.y       = y;
        r.read_index = idx;
        return r;
    endfunction

    task automatic issue_request(t_req r);
        int gap;
        gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 13) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= r.req_type;
        req_ch.point_x    <= r.pt.x;
        req_ch.point_y    <= r.pt.y;
        req_ch.read_index <= r.read_index;
        do @(posedge i_clk); while (!(req_ch.valid && req_ch.ready));
        sb.note_request(r);
        sent++;
    endtask

    task automatic append_point(logic signed [31:0] x, logic signed [31:0] y);
        issue_request(make_req(REQ_APPEND, x, y, 8'($urandom)));
    endtask

    task automatic read_entry(logic [7:0] idx);
        issue_request(make_req(REQ_READ, $urandom, $urandom, idx));
    endtask

    task automatic clear_stack();
        issue_request(make_req(REQ_CLEAR, $urandom, $urandom, 8'($urandom)));
    endtask

    task automatic await_results();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // axis-aligned walk around a random origin; small steps give merges and spikes
    task automatic run_walk(int n);
        logic signed [31:0] cx, cy, bx, by, tx, ty;
        int pick, delta;
        cx = $urandom;
        cy = $urandom;
        bx = cx;
        by = cy;
        for (int k = 0; k < n; k++) begin
            pick  = $urandom_range(0, 99);
            delta = $urandom_range(1, 4);
            if ($urandom_range(0, 1))
                delta = -delta;
            if (sb.depth > 200) begin
                clear_stack();
            end else if (pick < 60) begin
                bx = cx;
                by = cy;
                if ($urandom_range(0, 1))
                    cx = cx + 32'(delta);
                else
                    cy = cy + 32'(delta);
                append_point(cx, cy);
            end else if (pick < 72) begin
                tx = cx;
                ty = cy;
                cx = bx;
                cy = by;
                bx = tx;
                by = ty;
                append_point(cx, cy);
            end else if (pick < 80) begin
                append_point(cx, cy);
            end else if (pick < 91) begin
                if (sb.depth > 0 && $urandom_range(0, 3) != 0)
                    read_entry(8'($urandom_range(0, sb.depth - 1)));
                else
                    read_entry(8'($urandom_range(0, 255)));
            end else if (pick < 94) begin
                clear_stack();
            end else if (pick < 98) begin
                bx = cx;
                by = cy;
                cx = $urandom;
                cy = $urandom;
                append_point(cx, cy);
            end else begin
                issue_request(make_req(REQ_UNDEFINED, $urandom, $urandom, 8'($urandom)));
            end
        end
    endtask

    // fill to capacity, then duplicate, overflow and reads across the whole store
    task automatic run_fill();
        t_vertex top;
        clear_stack();
        while (sb.depth < MAX_POINTS_DEF)
            append_point($urandom, $urandom);
        top = sb.verts[sb.depth-1];
        append_point(top.x, top.y);
        append_point($urandom, $urandom);
        read_entry(8'd255);
        read_entry(8'd0);
        repeat (6) read_entry(8'($urandom_range(0, 255)));
    endtask

    initial begin
        int phase;
        sb                = new();
        idle_pct          = 0;
        sent              = 0;
        req_ch.valid      = 1'b0;
        req_ch.req_type   = REQ_APPEND;
        req_ch.point_x    = '0;
        req_ch.point_y    = '0;
        req_ch.read_index = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        idle_pct = 15;
        read_entry(8'd0);
        append_point(0, 0);
        append_point(0, 0);
        append_point(0, 5);
        append_point(0, 9);
        append_point(4, 9);
        append_point(10, 9);
        append_point(6, 9);
        append_point(12, 9);
        append_point(-3, 9);
        append_point(-3, 15);
        append_point(-3, 9);
        append_point(-3, 4);
        append_point(-3, 9);
        read_entry(8'd2);
        read_entry(8'd0);
        read_entry(8'd3);
        append_point(S32_MIN, S32_MIN);
        append_point(S32_MIN, S32_MAX);
        append_point(S32_MAX, S32_MAX);
        append_point(S32_MAX, S32_MIN);
        append_point(S32_MAX, 0);
        issue_request(make_req(REQ_UNDEFINED, S32_MAX, S32_MIN, 8'hff));
        clear_stack();
        read_entry(8'd0);
        await_results();

        phase = 0;
        while (sent < ITEMS) begin
            if (sent >= ITEMS - QUIET_TAIL)
                idle_pct = 0;
            else
                case ($urandom_range(0, 2))
                    0: idle_pct = 0;
                    1: idle_pct = 10;
                    default: idle_pct = 30;
                endcase
            if (phase == 2)
                run_fill();
            else
                run_walk($urandom_range(20, 60));
            if (phase == 2 || $urandom_range(0, 2) == 0)
                await_results();
            phase++;
        end

        await_results();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("rectilinear_path_point_reducer_top regression: pass");
        else
            $display("rectilinear_path_point_reducer_top regression: fail");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/rpr_pkg.sv
hw/rtl/rpr_if.sv
hw/rtl/rpr_ram.sv
hw/rtl/rpr_judge.sv
hw/rtl/rectilinear_path_point_reducer_top.sv
sim/rectilinear_path_point_reducer_top_tb.sv
